/* rtl/core/assert_macros.svh */
// Assertion macros for the RTL of the actuator block.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

/* rtl/core/aasd_pkg.sv */
// Package for the actuator acceleration and stepper delay block.
// Holds constants, codes and types; depends on nothing.
`default_nettype none
package aasd_pkg;
  localparam int ACTUATORS = 6;
  localparam int IDX_W = 3;
  localparam int W = 32;

  typedef enum logic [1:0] {
    OP_PREV = 2'd0,
    OP_FEEDBACK = 2'd1,
    OP_PRIME = 2'd2
  } op_t;

  localparam logic [0:0] REG_TIME_STEP = 1'b0;
  localparam logic [0:0] REG_FEED = 1'b1;

  // 676000^2 * 2^17 as the dividend of the delay division
  localparam logic [63:0] DELAY_NUM = 64'd456976000000 << 17;

  localparam logic [31:0] ACC_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] ACC_MIN = 32'h8000_0000;
endpackage
`default_nettype wire

/* rtl/core/actuator_accel_and_stepper_delay.sv */
// Actuator acceleration and first-step delay, top level.
// Each accepted input word runs a 75-step divide, a 75-step delay divide and a 32-step square
// root on the shared unit, with the sequencing states around them, before out_tvalid rises.
// The input takes no new word while one is in work; it stays not ready until the result is taken.
// Out-of-range actuator or prime words: result in the cycle after accept, next word once it is taken.
// Synchronous active-low reset clears state arrays and control and loads the default register values.
`default_nettype none
`include "assert_macros.svh"
module actuator_accel_and_stepper_delay (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [1:0] operation, [4:2] actuator, [36:5] target_length, [68:37] feedback_length
  input  wire logic [71:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [31:0] acceleration, [63:32] first_step_delay, [64] saturated
  output logic [71:0]      out_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [23:0] cfg_data
);
  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001, S_MUL1 = 10'b0000000010, S_DSQ = 10'b0000000100,
    S_DIV  = 10'b0000001000, S_ACC  = 10'b0000010000, S_VEL = 10'b0000100000,
    S_STEP = 10'b0001000000, S_DDIV = 10'b0010000000, S_SQRT = 10'b0100000000,
    S_OUT  = 10'b1000000000
  } state_t;

  state_t st_r, st_nxt;
  logic [23:0] dt_r, feed_r;
  logic signed [31:0] prev_r [aasd_pkg::ACTUATORS];
  logic signed [31:0] vel_r  [aasd_pkg::ACTUATORS];
  logic [1:0]  op_r;
  logic [2:0]  idx_r;
  logic signed [31:0] tgt_r, fb_r;
  logic signed [63:0] prod_r;
  logic [47:0] dsq_r;
  logic signed [34:0] num_r;
  logic signed [31:0] acc_r, delay_r;
  logic        clip_r, go_r;
  logic        out_valid_r;
  logic [64:0] out_data_r;
  logic        in_acc;
  logic signed [31:0] vcur;

  // shared unit ports
  logic        u_start, u_sqrt, u_done;
  logic [74:0] u_num, u_quo;
  logic [63:0] u_den;
  logic [64:0] u_rem;
  logic        x_start, x_sqrt;
  logic [74:0] x_num;
  logic [63:0] x_den;

  aasd_div u_div (
    .clk(clk), .rst_n(rst_n), .start(x_start), .sqrt_mode(x_sqrt),
    .num(x_num), .den(x_den), .done(u_done), .quo(u_quo), .rem(u_rem)
  );

  assign in_tready = (st_r == S_IDLE) && !go_r && !out_valid_r;
  assign in_acc = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign vcur = vel_r[idx_r];

  logic signed [35:0] vdt_rnd;
  logic signed [40:0] dv_rnd;
  logic [63:0] pmag;
  logic [63:0] smag;
  logic signed [41:0] vsum;
  logic [32:0] qr;

  always_comb begin
    st_nxt = st_r;
    u_start = 1'b0; u_sqrt = 1'b0; u_num = '0; u_den = '0;
    pmag = prod_r[63] ? 64'(-prod_r) : 64'(prod_r);
    smag = pmag;
    // round velocity*Q0.24 dt by 24 bits and acceleration*Q0.24 dt by 16 bits, ties away from zero
    vdt_rnd = prod_r[63] ? -36'((pmag + 64'd8388608) >> 24)
                         : 36'((pmag + 64'd8388608) >> 24);
    dv_rnd = prod_r[63] ? -41'((pmag + 64'd32768) >> 16)
                        : 41'((pmag + 64'd32768) >> 16);
    vsum = 42'(vcur) + 42'(dv_rnd);
    qr = u_quo[32:0] + ((u_rem >= 65'(dsq_r) - u_rem) ? 33'd1 : 33'd0);
    unique case (st_r)
      S_IDLE: if (go_r) st_nxt = S_MUL1;
      S_MUL1: st_nxt = S_DSQ;
      S_DSQ:  st_nxt = S_DIV;
      S_DIV: begin
        if (go_r) begin
          u_start = 1'b1;
          u_num = {8'd0, num_r[34] ? 35'(-num_r) : 35'(num_r), 32'd0} << 8;
          u_den = {16'd0, dsq_r};
        end
        if (u_done) st_nxt = S_ACC;
      end
      S_ACC:  st_nxt = S_VEL;
      S_VEL:  st_nxt = S_STEP;
      S_STEP: st_nxt = S_DDIV;
      S_DDIV: if (u_done) st_nxt = S_SQRT;
      S_SQRT: if (u_done) st_nxt = S_OUT;
      S_OUT:  st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; go_r <= 1'b0; out_valid_r <= 1'b0;
      dt_r <= 24'd167772; feed_r <= 24'd100000;
      for (int i = 0; i < aasd_pkg::ACTUATORS; i++) begin
        prev_r[i] <= '0; vel_r[i] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        if (cfg_index == aasd_pkg::REG_TIME_STEP) dt_r <= cfg_data;
        else feed_r <= cfg_data;
      end
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      go_r <= 1'b0;
      if (in_acc) begin
        op_r <= in_tdata[1:0]; idx_r <= in_tdata[4:2];
        tgt_r <= in_tdata[36:5]; fb_r <= in_tdata[68:37];
        clip_r <= 1'b0; acc_r <= '0;
        if (in_tdata[4:2] >= 3'(aasd_pkg::ACTUATORS)) begin
          out_data_r <= '0; out_valid_r <= 1'b1;
        end else if (in_tdata[1]) begin
          prev_r[in_tdata[4:2]] <= in_tdata[36:5];
          vel_r[in_tdata[4:2]] <= '0;
          out_data_r <= '0; out_valid_r <= 1'b1;
        end else begin
          go_r <= 1'b1;
        end
      end
      st_r <= st_nxt;
      unique case (st_r)
        S_MUL1: prod_r <= 64'(vcur) * $signed({1'b0, dt_r});
        S_DSQ: begin
          // form numerator and dt squared
          num_r <= 35'(tgt_r) - ((op_r == aasd_pkg::OP_PREV) ? 35'(prev_r[idx_r])
                   : 35'(fb_r)) - 35'(vdt_rnd);
          dsq_r <= dt_r * dt_r;
          go_r <= 1'b1;
        end
        S_DIV: begin
          if (u_done) begin
            if (num_r == '0) begin
              acc_r <= '0;
            end else if (dsq_r == '0 || u_quo[74:32] != '0) begin
              clip_r <= 1'b1;
              acc_r <= num_r[34] ? aasd_pkg::ACC_MIN : aasd_pkg::ACC_MAX;
            end else begin
              if (qr > 33'h80000000 || (!num_r[34] && qr > 33'h7FFFFFFF)) begin
                clip_r <= 1'b1;
                acc_r <= num_r[34] ? aasd_pkg::ACC_MIN : aasd_pkg::ACC_MAX;
              end else acc_r <= num_r[34] ? -32'(qr) : 32'(qr);
            end
          end
        end
        S_ACC: prod_r <= 64'(acc_r) * $signed({1'b0, dt_r});
        S_VEL: begin
          if (vsum > 42'sd2147483647) begin
            vel_r[idx_r] <= aasd_pkg::ACC_MAX; clip_r <= 1'b1;
          end else if (vsum < -42'sd2147483648) begin
            vel_r[idx_r] <= aasd_pkg::ACC_MIN; clip_r <= 1'b1;
          end else vel_r[idx_r] <= vsum[31:0];
          prev_r[idx_r] <= tgt_r;
          prod_r <= 64'(acc_r) * $signed({1'b0, feed_r});
        end
        default: ;
      endcase
      if (st_r == S_OUT) begin
        out_data_r <= {clip_r, delay_r, acc_r}; out_valid_r <= 1'b1;
      end
    end
  end

  // delay division and root run on the shared unit
  logic        zero_s_r;
  always_ff @(posedge clk) begin
    if (st_r == S_STEP) zero_s_r <= (prod_r == 0);
    if (st_r == S_SQRT && u_done)
      delay_r <= zero_s_r ? '0 : (prod_r[63] ? -32'(u_quo[31:0]) : 32'(u_quo[31:0]));
  end

  logic start_ddiv, start_sqrt;
  assign start_ddiv = (st_r == S_STEP);
  assign start_sqrt = (st_r == S_DDIV) && u_done;
  always_comb begin
    x_start = u_start; x_sqrt = u_sqrt; x_num = u_num; x_den = u_den;
    if (start_ddiv) begin
      x_start = 1'b1; x_num = {11'd0, aasd_pkg::DELAY_NUM};
      x_den = (smag == 0) ? 64'd1 : smag;
    end else if (start_sqrt) begin
      x_start = 1'b1; x_sqrt = 1'b1; x_num = {11'd0, u_quo[63:0]};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = {7'd0, out_data_r};

  `ASSERT_IMP(a_busy_not_ready, clk, rst_n, st_r != S_IDLE, !in_tready)
  `ASSERT_NXT(a_out_follows, clk, rst_n, st_r == S_OUT, out_valid_r)
  `ASSERT_IMP(a_idx_ok, clk, rst_n, st_r == S_VEL, idx_r < 3'(aasd_pkg::ACTUATORS))
endmodule
`default_nettype wire

/* rtl/core/aasd_div.sv */
// Shared restoring divider and square root unit, one bit a cycle.
// Depends on nothing; widths are fixed by the ports.
`default_nettype none
module aasd_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic        sqrt_mode,   // 1: floor sqrt of num[63:0]
  input  wire logic [74:0] num,         // dividend, msb first
  input  wire logic [63:0] den,
  output logic             done,
  output logic [74:0] quo,
  output logic [64:0] rem
);
  logic [74:0] num_r, num_nxt, num_step;
  logic [64:0] rem_r, rem_nxt, rem_step;
  logic [74:0] quo_r, quo_nxt, quo_step;
  logic [63:0] den_r, den_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, mode_r, mode_nxt;
  logic [65:0] trial;
  logic [64:0] shifted;
  logic [65:0] sub;

  // one step of the restoring digit recurrence for the active mode
  always_comb begin
    num_step = num_r; rem_step = rem_r; quo_step = quo_r;
    shifted = '0; trial = '0; sub = '0;
    if (mode_r) begin
      shifted = {rem_r[62:0], num_r[63:62]};
      trial = {quo_r[63:0], 2'b01};
      sub = {1'b0, shifted} - trial;
      num_step = {num_r[72:0], 2'b00};
      if (!sub[65]) begin
        rem_step = sub[64:0]; quo_step = {quo_r[73:0], 1'b1};
      end else begin
        rem_step = shifted; quo_step = {quo_r[73:0], 1'b0};
      end
    end else begin
      shifted = {rem_r[63:0], num_r[74]};
      sub = {1'b0, shifted} - {2'b00, den_r};
      num_step = {num_r[73:0], 1'b0};
      if (!sub[65]) begin
        rem_step = sub[64:0]; quo_step = {quo_r[73:0], 1'b1};
      end else begin
        rem_step = shifted; quo_step = {quo_r[73:0], 1'b0};
      end
    end
  end

  // load on start, else advance while busy
  always_comb begin
    num_nxt = num_r; rem_nxt = rem_r; quo_nxt = quo_r; den_nxt = den_r;
    cnt_nxt = cnt_r; busy_nxt = busy_r; mode_nxt = mode_r;
    if (start) begin
      num_nxt = num; den_nxt = den; rem_nxt = '0; quo_nxt = '0;
      mode_nxt = sqrt_mode; busy_nxt = 1'b1;
      cnt_nxt = sqrt_mode ? 7'd32 : 7'd75;
    end else if (busy_r) begin
      num_nxt = num_step; rem_nxt = rem_step; quo_nxt = quo_step;
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; cnt_r <= cnt_nxt;
    end
    num_r <= num_nxt; rem_r <= rem_nxt; quo_r <= quo_nxt;
    den_r <= den_nxt; mode_r <= mode_nxt;
  end

  assign done = busy_r && (cnt_r == 7'd1);
  assign quo = quo_step;
  assign rem = rem_step;
endmodule
`default_nettype wire

/* tb/sv/actuator_accel_and_stepper_delay_tb.sv */
// Testbench for the actuator acceleration and stepper first-step delay block.
// Drives random and directed words, predicts each result in a scoreboard class.
// Depends on aasd_pkg and the actuator_accel_and_stepper_delay RTL.
`timescale 1ns / 100ps

module actuator_accel_and_stepper_delay_tb;

  typedef struct packed {
    logic        sat;
    logic [31:0] dly;
    logic [31:0] acc;
  } accel_result_t;

  // Holds actuator state, register copies and the results still owed by the block
  class accel_scoreboard;
    longint        prev_tgt [aasd_pkg::ACTUATORS];
    longint        vel [aasd_pkg::ACTUATORS];
    longint        time_step;
    longint        feed;
    accel_result_t owed_results[$];
    int            errors;
    int            checked;
    int            primes;
    int            clipped;

    function new();
      time_step = 167772;
      feed = 100000;
      errors = 0;
      checked = 0;
      primes = 0;
      clipped = 0;
      foreach (prev_tgt[i]) begin
        prev_tgt[i] = 0;
        vel[i] = 0;
      end
    endfunction

    function void set_reg(logic [0:0] idx, logic [23:0] val);
      if (idx == aasd_pkg::REG_TIME_STEP) time_step = longint'(val);
      else feed = longint'(val);
    endfunction

    // Shift right rounding to nearest, ties away from zero
    function longint round_shift(longint v, int s);
      longint m;
      m = (v < 0) ? -v : v;
      m = (m + (longint'(1) << (s - 1))) >>> s;
      return (v < 0) ? -m : m;
    endfunction

    function longint clamp32(longint v, inout bit clip);
      if (v > 64'sd2147483647) begin
        clip = 1;
        return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
        clip = 1;
        return -64'sd2147483648;
      end
      return v;
    endfunction

    // Rounded diff * 2^40 / dt^2, saturated to 32 bits signed
    function longint accel_of(longint diff, inout bit clip);
      logic [63:0]  mag;
      logic [127:0] num;
      logic [127:0] dsq;
      logic [127:0] quo;
      logic [127:0] rem;
      longint       lim;
      mag = (diff < 0) ? -diff : diff;
      lim = (diff < 0) ? -64'sd2147483648 : 64'sd2147483647;
      if (mag == 0) return 0;
      dsq = 128'(time_step * time_step);
      if (dsq == 0) begin
        clip = 1;
        return lim;
      end
      num = {64'd0, mag} << 40;
      quo = num / dsq;
      rem = num % dsq;
      if (quo >= (128'd1 << 32)) begin
        clip = 1;
        return lim;
      end
      if (2 * rem >= dsq) quo = quo + 1;
      if (quo > 128'h8000_0000 || (diff > 0 && quo == 128'h8000_0000)) begin
        clip = 1;
        return lim;
      end
      return (diff < 0) ? -longint'(quo[63:0]) : longint'(quo[63:0]);
    endfunction

    function logic [63:0] int_root(logic [63:0] x);
      logic [63:0] r;
      logic [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x = x - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    // Predict the result of one accepted input word and update state
    function void note_word(logic [71:0] d);
      aasd_pkg::op_t op;
      int            act;
      longint        tgt;
      longint        fb;
      longint        refl;
      longint        a;
      longint        v;
      longint        s;
      logic [63:0]   m;
      logic [63:0]   dl;
      bit            clip;
      accel_result_t r;
      op = aasd_pkg::op_t'(d[1:0]);
      act = int'(d[4:2]);
      tgt = longint'($signed(d[36:5]));
      fb = longint'($signed(d[68:37]));
      r = '0;
      clip = 0;
      if (act < aasd_pkg::ACTUATORS) begin
        if (d[1]) begin
          prev_tgt[act] = tgt;
          vel[act] = 0;
          primes++;
        end else begin
          refl = (op == aasd_pkg::OP_PREV) ? prev_tgt[act] : fb;
          a = accel_of(tgt - refl - round_shift(vel[act] * time_step, 24), clip);
          v = clamp32(vel[act] + round_shift(a * time_step, 16), clip);
          vel[act] = v;
          prev_tgt[act] = tgt;
          s = a * feed;
          m = (s < 0) ? -s : s;
          dl = (m == 0) ? 64'd0 : int_root(aasd_pkg::DELAY_NUM / m);
          r.acc = a[31:0];
          r.dly = (s < 0) ? -dl[31:0] : dl[31:0];
          r.sat = clip;
          if (clip) clipped++;
        end
      end
      owed_results.push_back(r);
    endfunction

    // Compare one accepted result word with the oldest prediction
    function void check_word(logic [71:0] d);
      accel_result_t e;
      checked++;
      if (owed_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word %h", $time, d);
        return;
      end
      e = owed_results.pop_front();
      if (d[31:0] !== e.acc) begin
        errors++;
        $display("%0t: acceleration expected %0d actual %0d", $time,
                 $signed(e.acc), $signed(d[31:0]));
      end
      if (d[63:32] !== e.dly) begin
        errors++;
        $display("%0t: first_step_delay expected %0d actual %0d", $time,
                 $signed(e.dly), $signed(d[63:32]));
      end
      if (d[64] !== e.sat) begin
        errors++;
        $display("%0t: saturated expected %0b actual %0b", $time, e.sat, d[64]);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [0:0]  cfg_index;
  logic [23:0] cfg_data;

  accel_scoreboard sb;
  bit              no_gaps;
  bit              long_hold;
  longint          last_tgt [8];

  actuator_accel_and_stepper_delay dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial clk = 0;
  always #4 clk = ~clk;

  function int gap_len();
    return no_gaps ? 0 : int'($urandom_range(0, 18));
  endfunction

  // Watch both handshakes on every edge
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_word(in_tdata);
    if (rst_n && out_tvalid && out_tready) sb.check_word(out_tdata);
  end

  // Result side: random stalls, one long hold-off on request
  initial begin
    int n;
    out_tready = 0;
    @(posedge clk iff rst_n);
    forever begin
      if (long_hold) begin
        long_hold = 0;
        out_tready <= 0;
        repeat (400) @(posedge clk);
      end
      n = gap_len();
      if (n > 0) begin
        out_tready <= 0;
        repeat (n) @(posedge clk);
      end
      out_tready <= 1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  task automatic send_word(logic [1:0] op, logic [2:0] act, logic [31:0] tgt,
                           logic [31:0] fb);
    int n;
    n = gap_len();
    if (n > 0) begin
      in_tvalid <= 0;
      repeat (n) @(posedge clk);
    end
    in_tdata <= {3'd0, fb, tgt, act, op};
    in_tvalid <= 1;
    if (act < 3'(aasd_pkg::ACTUATORS)) last_tgt[act] = longint'($signed(tgt));
    do @(posedge clk); while (!in_tready);
  endtask

  // Hold until every owed result has arrived, then let the block settle
  task automatic drain();
    in_tvalid <= 0;
    @(posedge clk);
    while (sb.owed_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [23:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    sb.set_reg(idx, val);
  endtask

  function logic [31:0] rand_len(int act);
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'(last_tgt[act % aasd_pkg::ACTUATORS]
                          + $signed(32'($urandom_range(0, 4000))) - 2000);
    endcase
  endfunction

  task automatic random_words(int count);
    logic [1:0]  op;
    logic [2:0]  act;
    logic [31:0] tgt;
    for (int i = 0; i < count; i++) begin
      act = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                         : 3'($urandom_range(0, 5));
      case ($urandom_range(0, 11))
        0: op = aasd_pkg::OP_PRIME;
        1: op = 2'd3;
        2, 3, 4, 5: op = aasd_pkg::OP_FEEDBACK;
        default: op = aasd_pkg::OP_PREV;
      endcase
      tgt = rand_len(int'(act));
      send_word(op, act, tgt, $urandom_range(0, 2) ? rand_len(int'(act)) : $urandom());
    end
  endtask

  initial begin
    logic [23:0] ts_set [8];
    logic [23:0] fd_set [8];
    sb = new();
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    cfg_valid = 0;
    cfg_index = aasd_pkg::REG_TIME_STEP;
    cfg_data = '0;
    no_gaps = 0;
    long_hold = 0;
    foreach (last_tgt[i]) last_tgt[i] = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: extremes, every operation, out-of-range actuators, reset registers
    send_word(aasd_pkg::OP_PREV, 3'd0, 32'h0100_0000, 32'd0);
    send_word(aasd_pkg::OP_PREV, 3'd0, 32'h0100_0000, 32'd0);
    send_word(aasd_pkg::OP_FEEDBACK, 3'd1, 32'h7FFF_FFFF, 32'h8000_0000);
    send_word(aasd_pkg::OP_FEEDBACK, 3'd1, 32'h8000_0000, 32'h7FFF_FFFF);
    send_word(aasd_pkg::OP_FEEDBACK, 3'd2, 32'h0000_1000, 32'h0000_1000);
    send_word(aasd_pkg::OP_PRIME, 3'd3, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_word(aasd_pkg::OP_PREV, 3'd3, 32'h7FFF_FFFF, 32'd0);
    send_word(aasd_pkg::OP_PREV, 3'd3, 32'h8000_0000, 32'd0);
    send_word(2'd3, 3'd4, 32'h8000_0000, 32'd0);
    send_word(aasd_pkg::OP_PREV, 3'd4, 32'h8000_0001, 32'd0);
    send_word(aasd_pkg::OP_PREV, 3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(aasd_pkg::OP_FEEDBACK, 3'd6, 32'h1234_5678, 32'h0);
    send_word(aasd_pkg::OP_PRIME, 3'd7, 32'h1234_5678, 32'h0);
    send_word(aasd_pkg::OP_PREV, 3'd5, 32'h0000_0001, 32'd0);
    send_word(aasd_pkg::OP_FEEDBACK, 3'd0, 32'h0, 32'h0);
    drain();

    ts_set = '{24'd167772, 24'd1, 24'hFF_FFFF, 24'd0, 24'd16777, 24'd1677721, 24'd0, 24'd500};
    fd_set = '{24'd100000, 24'd1, 24'hFF_FFFF, 24'd100000, 24'd0, 24'd3000, 24'hFF_FFFF, 24'd1};
    for (int ph = 0; ph < 8; ph++) begin
      if (ph != 0) begin
        write_reg(aasd_pkg::REG_TIME_STEP,
                  ph == 7 ? 24'($urandom_range(1, 24'hFF_FFFF)) : ts_set[ph]);
        write_reg(aasd_pkg::REG_FEED, fd_set[ph]);
      end
      no_gaps = (ph % 3 == 1);
      if (ph == 2) long_hold = 1;
      random_words(115);
      if (ph == 4) drain();
      random_words(115);
      drain();
    end

    $display("Covered %0d results, %0d primes, %0d clipped, over 8 register settings.",
             sb.checked, sb.primes, sb.clipped);
    if (sb.errors == 0 && sb.owed_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #15_000_000;
    $display("Verification failed");
    $finish;
  end
endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/aasd_pkg.sv
rtl/core/aasd_div.sv
rtl/core/actuator_accel_and_stepper_delay.sv
tb/sv/actuator_accel_and_stepper_delay_tb.sv
